// ===== rtl/prq_pkg.sv =====
`timescale 1ns / 1ps

package prq_pkg;

    localparam int NUM_TASKS_DEF  = 128;
    localparam int NUM_LEVELS_DEF = 32;

    localparam int TASK_W  = 7;
    localparam int LEVEL_W = 5;
    localparam int DATA_W  = 16;
    localparam int PAD_W   = DATA_W - TASK_W - LEVEL_W;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_LINK = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    // Index of the lowest set bit, found by halving; zero word gives all ones.
    function automatic logic [LEVEL_W-1:0] lowest_set(input logic [31:0] word);
        logic [LEVEL_W-1:0] idx;
        logic [31:0]        v;
        idx = '0;
        v   = word;
        if (v[15:0] == 16'd0) begin
            idx[4] = 1'b1;
            v      = v >> 16;
        end
        if (v[7:0] == 8'd0) begin
            idx[3] = 1'b1;
            v      = v >> 8;
        end
        if (v[3:0] == 4'd0) begin
            idx[2] = 1'b1;
            v      = v >> 4;
        end
        if (v[1:0] == 2'd0) begin
            idx[1] = 1'b1;
            v      = v >> 2;
        end
        if (v[0] == 1'b0) begin
            idx[0] = 1'b1;
        end
        return idx;
    endfunction

endpackage

// ===== rtl/prq_ram.sv =====
`timescale 1ns / 1ps

module prq_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps

// Priority ready-queue scheduler: one FIFO of task numbers per priority level,
// threaded through a per-task link memory, with an occupancy bitmap on top.
//
// Request channel (s_*): s_tuser selects push (0) or pop (1); s_tdata carries
// the task number and its priority for a push. Result channel (m_*): m_tuser is
// the ok flag; m_tdata carries the popped task and its level, zero otherwise.
// Every request gives exactly one result.
//
// Sequencing: a push finishes in the execute state; a pop finishes there too,
// or in the link state when the level keeps further tasks and the next link
// must be fetched. The order is set by the dependent synchronous reads of the
// level memories and then the link memory. One request is in flight at a time;
// s_tready is high only while the sequencer is idle.
//
// A finished result sits in the output register, so the next request can be
// taken while it waits. If the receiver stalls and a second result is ready,
// the sequencer holds it and stops taking requests until the output drains.
//
// Reset empties every queue (bitmap cleared) and drops any pending result;
// the memories need no clearing pass.

module priority_ready_queue_scheduler #(
    parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [prq_pkg::DATA_W-1:0]  s_tdata,  // task_id[6:0], priority_req[11:7], zero pad
    input  logic                        s_tuser,  // req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [prq_pkg::DATA_W-1:0]  m_tdata,  // popped_task[6:0], popped_priority[11:7], pad
    output logic                        m_tuser   // ok
);

    import prq_pkg::*;

    localparam int AW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);

    // sequencer and request registers
    state_t                  state_reg, state_next;
    logic                    req_reg;
    logic [TASK_W-1:0]       task_reg;
    logic [LW-1:0]           lvl_reg;
    logic                    bad_reg;
    logic                    empty_reg;
    logic [TASK_W-1:0]       head_reg;
    logic [NUM_LEVELS-1:0]   occ_reg, occ_next;

    // result waiting behind a full output register
    logic                    res_ok_reg;
    logic [TASK_W-1:0]       res_task_reg;
    logic [LEVEL_W-1:0]      res_prio_reg;

    // output register
    logic                    m_tvalid_reg;
    logic                    m_ok_reg;
    logic [TASK_W-1:0]       m_task_reg;
    logic [LEVEL_W-1:0]      m_prio_reg;

    // request fields
    logic [TASK_W-1:0]       s_task;
    logic [LEVEL_W-1:0]      s_prio;
    logic                    s_accept;
    logic [LW-1:0]           pe_lvl;
    logic [LW-1:0]           rd_lvl;

    // memory ports
    logic                    oldest_we, newest_we, link_we;
    logic [TASK_W-1:0]       oldest_wdata;
    logic [TASK_W-1:0]       oldest_rdata, newest_rdata, link_rdata;
    logic [AW-1:0]           link_waddr, link_raddr;

    // completion of the current request
    logic                    fin;
    logic                    fin_ok;
    logic [TASK_W-1:0]       fin_task;
    logic [LEVEL_W-1:0]      fin_prio;
    logic                    out_free;

    assign s_task   = s_tdata[TASK_W-1:0];
    assign s_prio   = s_tdata[TASK_W+LEVEL_W-1:TASK_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // most urgent non-empty level
    assign pe_lvl = LW'(lowest_set(32'(occ_reg)));
    assign rd_lvl = (s_tuser == REQ_POP) ? pe_lvl : LW'(s_prio);

    assign link_waddr = AW'(newest_rdata);
    assign link_raddr = AW'(oldest_rdata);

    prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_oldest_ram (
        .aclk  (aclk),
        .we    (oldest_we),
        .waddr (lvl_reg),
        .wdata (oldest_wdata),
        .raddr (rd_lvl),
        .rdata (oldest_rdata)
    );

    prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_newest_ram (
        .aclk  (aclk),
        .we    (newest_we),
        .waddr (lvl_reg),
        .wdata (task_reg),
        .raddr (rd_lvl),
        .rdata (newest_rdata)
    );

    prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (task_reg),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        oldest_we    = 1'b0;
        newest_we    = 1'b0;
        link_we      = 1'b0;
        oldest_wdata = task_reg;
        fin          = 1'b0;
        fin_ok       = 1'b0;
        fin_task     = '0;
        fin_prio     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (req_reg)
                    REQ_PUSH: begin
                        fin = 1'b1;
                        if (!bad_reg) begin
                            fin_ok    = 1'b1;
                            newest_we = 1'b1;
                            if (!occ_reg[lvl_reg]) begin
                                // first task at this level: start the queue
                                oldest_we          = 1'b1;
                                occ_next[lvl_reg]  = 1'b1;
                            end else if (int'(newest_rdata) < NUM_TASKS) begin
                                // append behind the current newest task
                                link_we = 1'b1;
                            end
                        end
                    end
                    REQ_POP: begin
                        if (empty_reg) begin
                            fin = 1'b1;
                        end else if (oldest_rdata == newest_rdata) begin
                            // last task leaves: drop the level's bit
                            occ_next[lvl_reg] = 1'b0;
                            fin      = 1'b1;
                            fin_ok   = 1'b1;
                            fin_task = oldest_rdata;
                            fin_prio = LEVEL_W'(lvl_reg);
                        end else if (int'(oldest_rdata) < NUM_TASKS) begin
                            state_next = ST_LINK;
                        end else begin
                            fin      = 1'b1;
                            fin_ok   = 1'b1;
                            fin_task = oldest_rdata;
                            fin_prio = LEVEL_W'(lvl_reg);
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_LINK: begin
                // advance the oldest pointer to the fetched link
                oldest_we    = 1'b1;
                oldest_wdata = link_rdata;
                fin          = 1'b1;
                fin_ok       = 1'b1;
                fin_task     = head_reg;
                fin_prio     = LEVEL_W'(lvl_reg);
            end
            ST_RESP: begin
                fin      = 1'b1;
                fin_ok   = res_ok_reg;
                fin_task = res_task_reg;
                fin_prio = res_prio_reg;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (fin) begin
            state_next = out_free ? ST_IDLE : ST_RESP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (fin && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg   <= s_tuser;
            task_reg  <= s_task;
            lvl_reg   <= rd_lvl;
            bad_reg   <= (s_tuser == REQ_PUSH) &&
                         ((int'(s_task) >= NUM_TASKS) || (int'(s_prio) >= NUM_LEVELS));
            empty_reg <= (occ_reg == '0);
        end
        if (state_reg == ST_EXEC) begin
            head_reg <= oldest_rdata;
        end
        if (fin && out_free) begin
            m_ok_reg   <= fin_ok;
            m_task_reg <= fin_task;
            m_prio_reg <= fin_prio;
        end else if (fin) begin
            // hold the result until the receiver takes the previous one
            res_ok_reg   <= fin_ok;
            res_task_reg <= fin_task;
            res_prio_reg <= fin_prio;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_prio_reg, m_task_reg};

`ifndef ASSERT_OFF
    a_accept_starts_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not start execution");

    a_pop_level_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) && (req_reg == REQ_POP) && !empty_reg |-> occ_reg[lvl_reg])
        else $error("pop selected an empty level");

    a_link_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LINK) |-> ($past(state_reg) == ST_EXEC))
        else $error("link fetch entered out of sequence");

    a_fail_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0))
        else $error("failed request carries non-zero data");
`endif

endmodule

// ===== sim/tb_priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler;
    import prq_pkg::*;

    localparam int N_TASKS    = NUM_TASKS_DEF;
    localparam int N_LEVELS   = NUM_LEVELS_DEF;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int IDLE_LIMIT = 4000;

    // One result as the scheduler reports it.
    typedef struct packed {
        logic               ok;
        logic [TASK_W-1:0]  task_no;
        logic [LEVEL_W-1:0] level;
    } sched_result_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;  // task_id[6:0], priority_req[11:7], zero pad
    logic              s_tuser  = 1'b0; // req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;        // popped_task[6:0], popped_priority[11:7], pad
    logic              m_tuser;        // ok

    priority_ready_queue_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the scheduler: bitmap, per-level ends and per-task links.
    logic [N_LEVELS-1:0] occupied_levels = '0;
    logic [TASK_W-1:0]   newest_task [N_LEVELS];
    logic [TASK_W-1:0]   oldest_task [N_LEVELS];
    logic [TASK_W-1:0]   link_to     [N_TASKS];
    // Tasks sitting in some queue; a push only ever picks a task not marked here.
    bit                  task_queued [N_TASKS];
    int                  queued_count = 0;

    sched_result_t       pending_results [$];
    sched_result_t       got_result;
    sched_result_t       want_result;

    int mismatches  = 0;
    int idle_cycles = 0;

    // Traffic shaping, set by each test.
    int gap_max    = 0;  // longest sender gap between bursts; 0 keeps the sender busy
    int burst_left = 1;
    int stall_max  = 0;  // longest receiver stall; 0 keeps m_tready high
    int stall_left = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Work out the result of one request and advance the shadow queues.
    function automatic sched_result_t schedule_outcome(input logic req,
                                                       input logic [TASK_W-1:0] tid,
                                                       input logic [LEVEL_W-1:0] lvl);
        sched_result_t     r;
        int                lo;
        logic [TASK_W-1:0] head;
        r = '0;
        if (req == REQ_PUSH) begin
            // Empty level: the task becomes both ends; otherwise chain it behind the newest.
            if (!occupied_levels[lvl]) begin
                occupied_levels[lvl] = 1'b1;
                oldest_task[lvl]     = tid;
            end else begin
                link_to[newest_task[lvl]] = tid;
            end
            newest_task[lvl] = tid;
            task_queued[tid] = 1'b1;
            queued_count++;
            r.ok = 1'b1;
        end else if (occupied_levels != '0) begin
            // Most urgent level is the lowest set bit.
            lo = 0;
            while (!occupied_levels[lo]) lo++;
            head = oldest_task[lo];
            if (head == newest_task[lo]) begin
                occupied_levels[lo] = 1'b0;
            end else begin
                oldest_task[lo] = link_to[head];
            end
            task_queued[head] = 1'b0;
            queued_count--;
            r.ok      = 1'b1;
            r.task_no = head;
            r.level   = lo[LEVEL_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Present one request, hold it until taken, then log its expected result.
    // Valid stays high into the next request unless a gap is due.
    task automatic send_request(input logic req, input logic [TASK_W-1:0] tid,
                                input logic [LEVEL_W-1:0] lvl);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{PAD_W{1'b0}}, lvl, tid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(schedule_outcome(req, tid, lvl));
        if (gap_max > 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Pops straight after reset find nothing; the request fields must be ignored.
    task automatic test_pop_on_empty();
        gap_max   = 0;
        stall_max = 0;
        send_request(REQ_POP, 7'd127, 5'd31);
        send_request(REQ_POP, 7'd0, 5'd0);
        drain_all();
    endtask

    // Extreme task numbers and levels, a two-deep level, then a pop past empty.
    task automatic test_range_extremes();
        gap_max   = 0;
        stall_max = 3;
        send_request(REQ_PUSH, 7'd0, 5'd0);
        send_request(REQ_PUSH, 7'd127, 5'd31);
        send_request(REQ_PUSH, 7'd1, 5'd31);
        send_request(REQ_POP, 7'd127, 5'd31);
        send_request(REQ_POP, 7'd0, 5'd0);
        send_request(REQ_POP, 7'd85, 5'd10);
        send_request(REQ_POP, 7'd42, 5'd21);
        drain_all();
    endtask

    // Oldest first within a level, most urgent level first across levels.
    task automatic test_fifo_and_urgency();
        gap_max    = 3;
        burst_left = 2;
        stall_max  = 2;
        send_request(REQ_PUSH, 7'd10, 5'd9);
        send_request(REQ_PUSH, 7'd20, 5'd9);
        send_request(REQ_PUSH, 7'd30, 5'd9);
        send_request(REQ_PUSH, 7'd85, 5'd17);
        send_request(REQ_PUSH, 7'd64, 5'd3);
        send_request(REQ_PUSH, 7'd40, 5'd9);
        repeat (6) send_request(REQ_POP, 7'd0, 5'd0);
        drain_all();
    endtask

    // Mixed pushes and pops. Levels cluster in a narrow band most of the time so
    // that queues grow long; a quarter of pushes land anywhere.
    task automatic test_random_traffic(input int n_items, input int push_pct,
                                       input int level_base, input int level_span,
                                       input int gaps, input int stalls);
        int                 i;
        logic [TASK_W-1:0]  tid;
        logic [LEVEL_W-1:0] lvl;
        bit                 do_pop;
        gap_max    = gaps;
        stall_max  = stalls;
        burst_left = $urandom_range(1, 12);
        for (i = 0; i < n_items; i++) begin
            do_pop = ($urandom_range(0, 99) >= push_pct) || (queued_count == N_TASKS);
            if (do_pop) begin
                send_request(REQ_POP, TASK_W'($urandom_range(0, N_TASKS - 1)),
                             LEVEL_W'($urandom_range(0, N_LEVELS - 1)));
            end else begin
                // Never push a task that is already waiting somewhere.
                tid = TASK_W'($urandom_range(0, N_TASKS - 1));
                while (task_queued[tid]) tid = tid + 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    lvl = LEVEL_W'($urandom_range(0, N_LEVELS - 1));
                end else begin
                    lvl = LEVEL_W'(level_base + int'($urandom_range(0, level_span - 1)));
                end
                send_request(REQ_PUSH, tid, lvl);
            end
        end
        drain_all();
    endtask

    // Receiver: random stalls of up to stall_max cycles.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_max > 0 && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, stall_max - 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest outstanding expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = {m_tuser, m_tdata[TASK_W-1:0], m_tdata[TASK_W+LEVEL_W-1:TASK_W]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", int'(got_result), 0);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.ok !== want_result.ok)
                    report_mismatch("ok", int'(got_result.ok), int'(want_result.ok));
                if (got_result.task_no !== want_result.task_no)
                    report_mismatch("popped_task", int'(got_result.task_no),
                                    int'(want_result.task_no));
                if (got_result.level !== want_result.level)
                    report_mismatch("popped_priority", int'(got_result.level),
                                    int'(want_result.level));
            end
        end
    end

    // Count cycles without any handshake; reset the count on any request or result.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb_priority_ready_queue_scheduler NOT OK");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_pop_on_empty();
        test_range_extremes();
        test_fifo_and_urgency();
        // Phases: free running, bursty sender, stalling receiver, then both.
        test_random_traffic(400, 65, 0, 32, 0, 0);
        test_random_traffic(500, 55, 4, 3, 8, 0);
        test_random_traffic(500, 45, 20, 6, 0, 6);
        test_random_traffic(550, 50, 27, 5, 5, 3);

        // Hold a little longer to catch any stray result.
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_priority_ready_queue_scheduler OK");
        end else begin
            $display("tb_priority_ready_queue_scheduler NOT OK");
        end
        $finish;
    end

endmodule
